// File: rtl/core/crle_pkg.sv
// Shared types, widths and arithmetic helpers for the Catmull-Rom loop evaluator.
// No dependencies; imported by every module of the block.
package crle_pkg;

   localparam int DATA_W     = 32;   // Q16.16 coordinate
   localparam int PARAM_W    = 16;   // Q0.16 curve parameter
   localparam int CNT_W      = 7;    // point count register
   localparam int IDX_W      = 6;    // point index field
   localparam int COEF_W     = 38;   // doubled basis coefficients
   localparam int HW         = 40;   // Horner partial results
   localparam int WIDE_W     = 64;   // rounding and saturation width
   localparam int MAX_POINTS_DEF = 64;
   localparam logic [CNT_W-1:0] CNT_RESET = 7'd4;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } point_type;

   // Round half up, then shift right arithmetically by k.
   function automatic logic signed [WIDE_W-1:0] rnd_shift(
      input logic signed [WIDE_W-1:0] x,
      input int unsigned k);
      logic signed [WIDE_W-1:0] half;
      half = 64'sd1 <<< (k - 1);
      return (x + half) >>> k;
   endfunction

   // Clamp to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/catmull_rom_loop_evaluator.sv
// Top level of the closed-loop Catmull-Rom evaluator: command intake, index
// pipeline, four point table banks and three axis datapaths.
// Depends on crle_pkg, crle_point_ram and crle_axis.
//
// Usage:
//   Commands enter on start/req_*; a beat is taken at each edge where start is
//   high and busy is low. busy is high only during reset, so one command can
//   enter every cycle. req_mode 0 writes point req_point_index (no result);
//   req_mode 1 evaluates at req_curve_param and yields one result.
//   Results leave on rsp_* with rsp_valid high for exactly one cycle, in
//   command order. Throughput is one command
//   per cycle, set by four table banks each giving one read per cycle and a
//   fully pipelined multiply chain of seven stages per axis.
//   The receiver cannot stall; nothing inside ever holds.
//   csr_* writes the point count (1..MAX_POINTS; 0 acts as 1, larger values
//   clamp); write it only while no evaluation is in flight.
//   Reset clears the pipeline valid bits and sets the point count to 4. The
//   point table is not cleared: write each point before evaluating over it.
module catmull_rom_loop_evaluator import crle_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_coord_x,
   input  logic signed [DATA_W-1:0] req_coord_y,
   input  logic signed [DATA_W-1:0] req_coord_z,
   input  logic [PARAM_W-1:0]       req_curve_param,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_pos_x,
   output logic signed [DATA_W-1:0] rsp_pos_y,
   output logic signed [DATA_W-1:0] rsp_pos_z,
   output logic signed [DATA_W-1:0] rsp_tan_x,
   output logic signed [DATA_W-1:0] rsp_tan_y,
   output logic signed [DATA_W-1:0] rsp_tan_z,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CNT_W-1:0]         csr_data
);

   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int UW  = PARAM_W + NW;
   localparam int LAT = 10;

   logic               accept;
   logic [CNT_W-1:0]   point_count_ff, point_count_in;
   logic [NW-1:0]      n_clamp;
   logic [LAT-1:0]     vld_ff, vld_in;

   logic               s1_wr_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   point_type          s1_crd_ff;
   logic [PARAM_W-1:0] s1_prm_ff;
   logic [NW-1:0]      s1_n_ff;

   logic               s2_wr_ff;
   logic [AW-1:0]      s2_waddr_ff;
   point_type          s2_crd_ff;
   logic [UW-1:0]      s2_u_ff;
   logic [NW-1:0]      s2_n_ff;
   logic [PARAM_W-1:0] s3_f_ff;

   logic [AW-1:0]      seg;
   logic [NW-1:0]      seg_n, nxt1, nxt2;
   logic [AW-1:0]      rd_addr [4];
   point_type          rd_data [4];

   assign accept    = start && !busy;
   assign busy      = reset;
   assign csr_ready = !reset;

   // Point count register
   always_comb begin
      point_count_in = point_count_ff;
      if (csr_valid && csr_ready) begin
         point_count_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= CNT_RESET;
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   // Clamp the count into 1..MAX_POINTS
   always_comb begin
      if (point_count_ff == '0) begin
         n_clamp = NW'(1);
      end else if (32'(point_count_ff) > 32'(MAX_POINTS)) begin
         n_clamp = NW'(MAX_POINTS);
      end else begin
         n_clamp = NW'(point_count_ff);
      end
   end

   // Advance the valid bits of evaluate beats
   assign vld_in = {vld_ff[LAT-2:0], accept && req_mode};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         s1_wr_ff <= 1'b0;
         s2_wr_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         s1_wr_ff <= accept && !req_mode && (32'(req_point_index) < 32'(MAX_POINTS));
         s2_wr_ff <= s1_wr_ff;
      end
   end

   // Stage 1: capture the command
   always_ff @(posedge clock) begin
      s1_idx_ff <= req_point_index;
      s1_crd_ff <= '{x: req_coord_x, y: req_coord_y, z: req_coord_z};
      s1_prm_ff <= req_curve_param;
      s1_n_ff   <= n_clamp;
   end

   // Stage 2: scale the parameter by the count
   always_ff @(posedge clock) begin
      s2_u_ff     <= UW'(s1_prm_ff) * UW'(s1_n_ff);
      s2_n_ff     <= s1_n_ff;
      s2_waddr_ff <= AW'(32'(s1_idx_ff));
      s2_crd_ff   <= s1_crd_ff;
   end

   // Wrapped neighbor indexes s-1, s, s+1, s+2
   assign seg   = s2_u_ff[PARAM_W +: AW];
   assign seg_n = NW'(seg);
   assign nxt1  = (seg_n + NW'(1) == s2_n_ff) ? '0 : seg_n + NW'(1);
   assign nxt2  = (nxt1 + NW'(1) == s2_n_ff) ? '0 : nxt1 + NW'(1);

   always_comb begin
      rd_addr[0] = (seg == '0) ? AW'(s2_n_ff - NW'(1)) : seg - AW'(1);
      rd_addr[1] = seg;
      rd_addr[2] = AW'(nxt1);
      rd_addr[3] = AW'(nxt2);
   end

   // Four identical banks: every write lands in all, each read takes one
   for (genvar k = 0; k < 4; k++) begin : g_bank
      crle_point_ram #(
         .DEPTH (MAX_POINTS),
         .AW    (AW)
      ) u_ram (
         .clock   (clock),
         .wr_en   (s2_wr_ff),
         .wr_addr (s2_waddr_ff),
         .wr_data (s2_crd_ff),
         .rd_addr (rd_addr[k]),
         .rd_data (rd_data[k])
      );
   end

   // Stage 3: hold the local fraction beside the read data
   always_ff @(posedge clock) begin
      s3_f_ff <= s2_u_ff[PARAM_W-1:0];
   end

   crle_axis u_axis_x (
      .clock (clock),
      .p0    (rd_data[0].x), .p1 (rd_data[1].x),
      .p2    (rd_data[2].x), .p3 (rd_data[3].x),
      .frac  (s3_f_ff),
      .pos   (rsp_pos_x),
      .tan   (rsp_tan_x)
   );

   crle_axis u_axis_y (
      .clock (clock),
      .p0    (rd_data[0].y), .p1 (rd_data[1].y),
      .p2    (rd_data[2].y), .p3 (rd_data[3].y),
      .frac  (s3_f_ff),
      .pos   (rsp_pos_y),
      .tan   (rsp_tan_y)
   );

   crle_axis u_axis_z (
      .clock (clock),
      .p0    (rd_data[0].z), .p1 (rd_data[1].z),
      .p2    (rd_data[2].z), .p3 (rd_data[3].z),
      .frac  (s3_f_ff),
      .pos   (rsp_pos_z),
      .tan   (rsp_tan_z)
   );

   assign rsp_valid = vld_ff[LAT-1];

   // A result strobe follows an evaluate beat by a fixed latency
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_mode, LAT))
      else $error("result strobe without matching evaluate beat");

   // Neighbor indexes stay inside the loop
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (NW'(rd_addr[0]) < s2_n_ff) && (NW'(rd_addr[2]) < s2_n_ff)
                    && (NW'(rd_addr[3]) < s2_n_ff) && (seg_n < s2_n_ff))
      else $error("neighbor index outside point loop");

   // A table write and an evaluate never share stage 2
   a_stage2_excl: assert property (@(posedge clock) disable iff (reset)
      s2_wr_ff |-> !vld_ff[1])
      else $error("write and evaluate in the same stage");

endmodule

// File: rtl/core/crle_point_ram.sv
// One bank of the control point table: one write port, one registered read port.
// Depends on crle_pkg for point_type.
module crle_point_ram import crle_pkg::*; #(
   parameter int DEPTH = MAX_POINTS_DEF,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  point_type     wr_data,
   input  logic [AW-1:0] rd_addr,
   output point_type     rd_data
);

   point_type mem [DEPTH];
   point_type rd_data_ff;

   // Write one point per beat
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read old contents, register the data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/crle_axis.sv
// Seven-stage fixed-latency datapath for one axis: basis coefficients,
// Horner evaluation of position and tangent, rounding and saturation.
// Depends on crle_pkg for widths and helpers.
module crle_axis import crle_pkg::*; (
   input  logic                      clock,
   input  logic signed [DATA_W-1:0]  p0,
   input  logic signed [DATA_W-1:0]  p1,
   input  logic signed [DATA_W-1:0]  p2,
   input  logic signed [DATA_W-1:0]  p3,
   input  logic [PARAM_W-1:0]        frac,
   output logic signed [DATA_W-1:0]  pos,
   output logic signed [DATA_W-1:0]  tan
);

   localparam int PROD0_W = COEF_W + PARAM_W + 1;
   localparam int PRODH_W = HW + PARAM_W + 1;

   // stage 1: coefficients
   logic signed [COEF_W-1:0] b0_ff, b1_ff, b2_ff, b1_2_ff, b2_2_ff, b2_3_ff, b2_4_ff;
   logic signed [DATA_W-1:0] p1_1_ff, p1_2_ff, p1_3_ff, p1_4_ff, p1_5_ff, p1_6_ff;
   logic [PARAM_W-1:0]       f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic signed [PROD0_W-1:0] prod0_ff;
   logic signed [HW-1:0]     h1_ff, g1_ff, h2_ff;
   logic signed [PRODH_W-1:0] prod1_ff, prod2_ff, prod3_ff;
   logic signed [DATA_W-1:0] tan5_ff, tan6_ff, pos_ff, tan_ff;

   logic signed [COEF_W-1:0] e0, e1, e2, e3;
   logic signed [WIDE_W-1:0] h1_in, g1_in, h2_in, t_in, pos_in, pr0;

   assign e0 = COEF_W'(p0);
   assign e1 = COEF_W'(p1);
   assign e2 = COEF_W'(p2);
   assign e3 = COEF_W'(p3);

   always_ff @(posedge clock) begin
      b0_ff   <= -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
      b1_ff   <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      b2_ff   <= e2 - e0;
      p1_1_ff <= p1;
      f1_ff   <= frac;
   end

   // stage 2: leading product
   always_ff @(posedge clock) begin
      prod0_ff <= b0_ff * $signed({1'b0, f1_ff});
      b1_2_ff  <= b1_ff;
      b2_2_ff  <= b2_ff;
      p1_2_ff  <= p1_1_ff;
      f2_ff    <= f1_ff;
   end

   // stage 3: first Horner step for position and tangent
   assign pr0   = WIDE_W'(prod0_ff);
   assign h1_in = rnd_shift(pr0 + (WIDE_W'(b1_2_ff) <<< 16), 16);
   assign g1_in = rnd_shift((pr0 <<< 1) + pr0 + (WIDE_W'(b1_2_ff) <<< 17), 16);

   always_ff @(posedge clock) begin
      h1_ff   <= h1_in[HW-1:0];
      g1_ff   <= g1_in[HW-1:0];
      b2_3_ff <= b2_2_ff;
      p1_3_ff <= p1_2_ff;
      f3_ff   <= f2_ff;
   end

   // stage 4: second products
   always_ff @(posedge clock) begin
      prod1_ff <= h1_ff * $signed({1'b0, f3_ff});
      prod2_ff <= g1_ff * $signed({1'b0, f3_ff});
      b2_4_ff  <= b2_3_ff;
      p1_4_ff  <= p1_3_ff;
      f4_ff    <= f3_ff;
   end

   // stage 5: second Horner step, tangent done
   assign h2_in = rnd_shift(WIDE_W'(prod1_ff) + (WIDE_W'(b2_4_ff) <<< 16), 16);
   assign t_in  = rnd_shift(WIDE_W'(prod2_ff) + (WIDE_W'(b2_4_ff) <<< 16), 17);

   always_ff @(posedge clock) begin
      h2_ff   <= h2_in[HW-1:0];
      tan5_ff <= sat32(t_in);
      p1_5_ff <= p1_4_ff;
      f5_ff   <= f4_ff;
   end

   // stage 6: last product
   always_ff @(posedge clock) begin
      prod3_ff <= h2_ff * $signed({1'b0, f5_ff});
      tan6_ff  <= tan5_ff;
      p1_6_ff  <= p1_5_ff;
   end

   // stage 7: add the base point and saturate
   assign pos_in = rnd_shift(WIDE_W'(prod3_ff), 17) + WIDE_W'(p1_6_ff);

   always_ff @(posedge clock) begin
      pos_ff <= sat32(pos_in);
      tan_ff <= tan6_ff;
   end

   assign pos = pos_ff;
   assign tan = tan_ff;

endmodule
